// File: src/tpbc_pkg.sv
// tpbc_pkg: shared types and constants of the tilt pid balance controller
// depends on nothing
package tpbc_pkg;

    localparam int ATAN_LEN = 24;

    function automatic logic signed [23:0] atan_q16(input logic [4:0] idx);
        logic signed [23:0] v;
        case (idx)
            5'd0:  v = 24'sd2949120;
            5'd1:  v = 24'sd1740967;
            5'd2:  v = 24'sd919879;
            5'd3:  v = 24'sd466945;
            5'd4:  v = 24'sd234379;
            5'd5:  v = 24'sd117304;
            5'd6:  v = 24'sd58666;
            5'd7:  v = 24'sd29335;
            5'd8:  v = 24'sd14668;
            5'd9:  v = 24'sd7334;
            5'd10: v = 24'sd3667;
            5'd11: v = 24'sd1833;
            5'd12: v = 24'sd917;
            5'd13: v = 24'sd458;
            5'd14: v = 24'sd229;
            5'd15: v = 24'sd115;
            5'd16: v = 24'sd57;
            5'd17: v = 24'sd29;
            5'd18: v = 24'sd14;
            5'd19: v = 24'sd7;
            5'd20: v = 24'sd4;
            5'd21: v = 24'sd2;
            5'd22: v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    localparam logic [2:0] REG_SETPOINT = 3'd0;
    localparam logic [2:0] REG_GAIN_P   = 3'd1;
    localparam logic [2:0] REG_GAIN_I   = 3'd2;
    localparam logic [2:0] REG_GAIN_D   = 3'd3;
    localparam logic [2:0] REG_DUTY_MAX = 3'd4;
    localparam logic [2:0] REG_DUTY_MIN = 3'd5;
    localparam logic [2:0] REG_GYRO_B   = 3'd6;
    localparam logic [2:0] REG_ACC_B    = 3'd7;

    localparam logic signed [17:0] SAT_HI = 18'sd131071;
    localparam logic signed [17:0] SAT_LO = -18'sd131072;
    localparam logic signed [19:0] GYRO_Q32 = 20'sd10010;
    localparam logic signed [19:0] W_GYRO = 20'sd52429;
    localparam logic signed [19:0] W_ACC  = 20'sd13107;

    // sequencer states
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_CORD  = 12'b000000000010,
        ST_ACC   = 12'b000000000100,
        ST_GYRO  = 12'b000000001000,
        ST_BL1   = 12'b000000010000,
        ST_BL2   = 12'b000000100000,
        ST_ERR   = 12'b000001000000,
        ST_INT   = 12'b000010000000,
        ST_PROP  = 12'b000100000000,
        ST_DER   = 12'b001000000000,
        ST_DUTY  = 12'b010000000000,
        ST_OUT   = 12'b100000000000
    } state_t;

    typedef struct packed {
        logic start;
    } cordic_ctl_t;

endpackage

// File: src/tilt_pid_balance_controller.sv
// tilt_pid_balance_controller: top level, sequencer, shared multiplier, apb registers
// depends on tpbc_pkg and tpbc_cordic
//
// one imu sample in (accel y/z, gyro x), one result out: pwm duty, direction, the
// filtered pitch and the tilt error, angles in degrees with 8 fraction bits.
// the serial cordic iteration dominates each item; the rest is one step a cycle through a
// single shared 40x20 multiplier. s_tready is high only while the sequencer is
// idle; the result sits in an output register until taken, and the block takes
// the next sample only after that. the first sample after reset loads the pitch
// from the accelerometer alone, later ones blend 0.8 gyro-integrated pitch with
// 0.2 accelerometer pitch. registers lie at byte address 4*i and may be written
// only when the block is idle.
module tilt_pid_balance_controller import tpbc_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_y [15:0], accel_z [31:16], gyro_x [47:32]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // duty [9:0], forward [10], pitch_angle [28:11], tilt_error [46:29], zero fill
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int F = 8;

    // configuration registers
    logic signed [16:0] setpoint_reg, accb_reg;
    logic [15:0]        gp_reg, gi_reg, gd_reg;
    logic signed [15:0] gyrob_reg;
    logic [9:0]         dmax_reg, dmin_reg;
    logic               wr_en;
    logic [2:0]         ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= 17'sd23040;
            gp_reg <= 16'd256;
            gi_reg <= 16'd307;
            gd_reg <= 16'd333;
            dmax_reg <= 10'd100;
            dmin_reg <= 10'd5;
            gyrob_reg <= '0;
            accb_reg <= '0;
        end else if (wr_en) begin
            case (ridx)
                REG_SETPOINT: setpoint_reg <= pwdata[16:0];
                REG_GAIN_P:   gp_reg <= pwdata[15:0];
                REG_GAIN_I:   gi_reg <= pwdata[15:0];
                REG_GAIN_D:   gd_reg <= pwdata[15:0];
                REG_DUTY_MAX: dmax_reg <= pwdata[9:0];
                REG_DUTY_MIN: dmin_reg <= pwdata[9:0];
                REG_GYRO_B:   gyrob_reg <= pwdata[15:0];
                REG_ACC_B:    accb_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_SETPOINT: prdata = {{15{setpoint_reg[16]}}, setpoint_reg};
            REG_GAIN_P:   prdata = {16'd0, gp_reg};
            REG_GAIN_I:   prdata = {16'd0, gi_reg};
            REG_GAIN_D:   prdata = {16'd0, gd_reg};
            REG_DUTY_MAX: prdata = {22'd0, dmax_reg};
            REG_DUTY_MIN: prdata = {22'd0, dmin_reg};
            REG_GYRO_B:   prdata = {{16{gyrob_reg[15]}}, gyrob_reg};
            REG_ACC_B:    prdata = {{15{accb_reg[16]}}, accb_reg};
            default:      prdata = '0;
        endcase
    end

    // controller state
    state_t state_reg, state_next;
    logic signed [15:0] gx_reg;
    logic signed [17:0] pitch_reg, perr_reg, err_reg, acc_reg;
    logic [19:0]        integ_reg;
    logic               first_reg;
    logic signed [47:0] accum_reg;   // running sum of products
    logic signed [47:0] prod_reg;
    logic               out_valid_reg;
    logic [9:0]         duty_reg;

    cordic_ctl_t        cctl;
    logic               cdone;
    logic signed [25:0] cang;

    assign cctl.start = (state_reg == ST_IDLE) && s_tvalid && s_tready;

    tpbc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cctl.start),
        .ay(s_tdata[15:0]), .az(s_tdata[31:16]),
        .done(cdone), .ang_q16(cang)
    );

    // shared multiplier: 40 bit signed by 20 bit signed
    logic signed [39:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [59:0] mul_p;
    assign mul_p = mul_a * mul_b;

    function automatic logic signed [17:0] sat18(input logic signed [47:0] v);
        if (v > 48'(SAT_HI)) return SAT_HI;
        if (v < 48'(SAT_LO)) return SAT_LO;
        return v[17:0];
    endfunction

    logic signed [47:0] ang_round, gdiff, dterm;
    assign ang_round = ((48'(cang) + 48'sd128) >>> (16 - F)) + 48'sd23040 - 48'(accb_reg);
    assign gdiff = 48'(gx_reg) - 48'(gyrob_reg);
    assign dterm = 48'(err_reg) - 48'(perr_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_GYRO: begin mul_a = 40'(gdiff); mul_b = GYRO_Q32; end
            ST_BL1:  begin mul_a = 40'(accum_reg); mul_b = W_GYRO; end
            ST_BL2:  begin mul_a = 40'(acc_reg); mul_b = W_ACC; end
            ST_INT:  begin mul_a = 40'(err_reg); mul_b = $signed({4'd0, gi_reg}); end
            ST_PROP: begin mul_a = 40'(err_reg); mul_b = $signed({4'd0, gp_reg}); end
            ST_DER:  begin mul_a = 40'(dterm); mul_b = $signed({4'd0, gd_reg}); end
            ST_DUTY: begin mul_a = 40'(accum_reg); mul_b = 20'sd10; end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_CORD;
            ST_CORD: if (cdone) state_next = ST_ACC;
            ST_ACC:  state_next = first_reg ? ST_ERR : ST_GYRO;
            ST_GYRO: state_next = ST_BL1;
            ST_BL1:  state_next = ST_BL2;
            ST_BL2:  state_next = ST_ERR;
            ST_ERR:  state_next = ST_INT;
            ST_INT:  state_next = ST_PROP;
            ST_PROP: state_next = ST_DER;
            ST_DER:  state_next = ST_DUTY;
            ST_DUTY: state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic signed [47:0] ip, hi, lo, tt, hik, lok;
    assign hi = 48'({dmax_reg, 10'd0});
    assign lo = 48'({dmin_reg, 10'd0});
    assign hik = 48'({dmax_reg, 16'd0});
    assign lok = 48'({dmin_reg, 16'd0});
    // integral zero-extended into a signed sum so the rounded increment shifts arithmetically
    assign ip = $signed({28'd0, integ_reg}) + ((48'(mul_p) + 48'sd32) >>> (F - 2));
    assign tt = 48'(mul_p);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b1;
            pitch_reg <= '0;
            integ_reg <= '0;
            perr_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_tvalid && s_tready) begin
                    gx_reg <= s_tdata[47:32];
                end
                ST_ACC: begin
                    acc_reg <= sat18(ang_round);
                    if (first_reg) begin
                        pitch_reg <= sat18(ang_round);
                        first_reg <= 1'b0;
                    end
                end
                ST_GYRO: begin
                    // pitch plus rounded gyro increment
                    accum_reg <= 48'(pitch_reg) +
                        ((48'(mul_p) + 48'sd8388608) >>> (32 - F));
                end
                ST_BL1: prod_reg <= 48'(mul_p);
                ST_BL2: begin
                    accum_reg <= prod_reg;
                    pitch_reg <= sat18((prod_reg + 48'(mul_p) + 48'sd32768) >>> 16);
                end
                ST_ERR: err_reg <= sat18(48'(setpoint_reg) - 48'(pitch_reg));
                ST_INT: begin
                    if (ip > hi) integ_reg <= hi[19:0];
                    else if (ip < lo) integ_reg <= lo[19:0];
                    else integ_reg <= ip[19:0];
                end
                ST_PROP: accum_reg <= 48'(mul_p) + (48'(integ_reg) <<< (F - 2));
                ST_DER: begin
                    accum_reg <= accum_reg - 48'(mul_p);
                    perr_reg <= err_reg;
                end
                ST_DUTY: begin
                    if (tt > hik) duty_reg <= dmax_reg;
                    else if (tt < lok) duty_reg <= dmin_reg;
                    else duty_reg <= tt[25:16];
                end
                ST_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, err_reg, pitch_reg, (err_reg > 0), duty_reg};
endmodule

// File: src/tpbc_cordic.sv
// tpbc_cordic: iterative vectoring cordic giving atan2 in degrees, q.16
// depends on tpbc_pkg
module tpbc_cordic import tpbc_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] az,
    output logic               done,
    output logic signed [25:0] ang_q16
);
    localparam int NSTEP = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;

    logic signed [27:0] x_reg, y_reg;
    // room for the overshoot past 180 degrees while converging
    logic signed [25:0] ang_reg;
    logic [4:0]         i_reg;
    logic               run_reg, done_reg;
    logic signed [27:0] xs, ys, x0, y0;
    logic signed [25:0] a0;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;

    always_comb begin
        x0 = {{4{az[15]}}, az, 8'd0};
        y0 = {{4{ay[15]}}, ay, 8'd0};
        a0 = '0;
        if (az < 0) begin
            if (ay >= 0) begin
                x0 = {{4{ay[15]}}, ay, 8'd0};
                y0 = -{{4{az[15]}}, az, 8'd0};
                a0 = 26'sd5898240;
            end else begin
                x0 = -{{4{ay[15]}}, ay, 8'd0};
                y0 = {{4{az[15]}}, az, 8'd0};
                a0 = -26'sd5898240;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg <= x0;
                y_reg <= y0;
                ang_reg <= a0;
                i_reg <= '0;
                // y zero with z non-negative gives exact zero
                if (ay == 0 && az >= 0) begin
                    ang_reg  <= '0;
                    done_reg <= 1'b1;
                end else begin
                    run_reg <= 1'b1;
                end
            end else if (run_reg) begin
                if (y_reg >= 0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    ang_reg <= ang_reg + atan_q16(i_reg);
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    ang_reg <= ang_reg - atan_q16(i_reg);
                end
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(NSTEP - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign ang_q16 = ang_reg;
endmodule

// File: src/tpbc_checker.sv
// tpbc_checker: port-level checks on the tilt pid balance controller
// depends on tpbc_pkg and the top level it binds to
module tpbc_checker import tpbc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        pready
);
    // no new sample while a result waits
    a_no_in_when_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    // a sample is followed by a busy cycle
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");
    // result holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    // forward agrees with error sign
    a_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10] == (!m_tdata[46] && (m_tdata[45:29] != 17'd0))))
        else $error("forward mismatch");
    a_pready: assert property (@(posedge aclk) pready) else $error("pready low");
endmodule

bind tilt_pid_balance_controller tpbc_checker u_tpbc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
